@@ hdl/quaternion_to_euler_assert.svh @@
// ----------------------------------------------------------------------------
// Quaternion to Euler assertion macros
// Small set of concurrent assertion helpers used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// implication checked every clock, off during reset
`define Q2E_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define Q2E_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler package
// Shared constants, CORDIC angle table and helper types.
// ----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
  localparam int QW = 16;
  localparam int MW = 34;
  localparam int ZW = 34;
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [MW-1:0] ONE_Q28 = 34'sd268435456;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'h03243F6A8;
      5'd1: atan_q30 = 34'h01DAC6705;
      5'd2: atan_q30 = 34'h00FADBAFC;
      5'd3: atan_q30 = 34'h007F56EA6;
      5'd4: atan_q30 = 34'h003FEAB76;
      5'd5: atan_q30 = 34'h001FFD55B;
      5'd6: atan_q30 = 34'h000FFFAAA;
      5'd7: atan_q30 = 34'h0007FFF55;
      5'd8: atan_q30 = 34'h0003FFFEA;
      5'd9: atan_q30 = 34'h0001FFFFD;
      5'd10: atan_q30 = 34'h0000FFFFF;
      5'd11: atan_q30 = 34'h00007FFFF;
      5'd12: atan_q30 = 34'h00003FFFF;
      5'd13: atan_q30 = 34'h00001FFFF;
      5'd14: atan_q30 = 34'h00000FFFF;
      5'd15: atan_q30 = 34'h000007FFF;
      5'd16: atan_q30 = 34'h000003FFF;
      5'd17: atan_q30 = 34'h000001FFF;
      5'd18: atan_q30 = 34'h000000FFF;
      5'd19: atan_q30 = 34'h0000007FF;
      5'd20: atan_q30 = 34'h0000003FF;
      5'd21: atan_q30 = 34'h0000001FF;
      5'd22: atan_q30 = 34'h0000000FF;
      5'd23: atan_q30 = 34'h00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  typedef struct packed {
    logic signed [MW-1:0] m32;
    logic signed [MW-1:0] m33;
    logic signed [MW-1:0] v;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m11;
  } q2e_mat_t;
endpackage
`default_nettype wire

@@ hdl/q2e_front.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler front end
// Forms the matrix elements and clamps the asin argument, three stages.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_front
  import q2e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_vld,
  input  wire logic signed [QW-1:0] quat_x,
  input  wire logic signed [QW-1:0] quat_y,
  input  wire logic signed [QW-1:0] quat_z,
  input  wire logic signed [QW-1:0] quat_w,
  output logic [1:0] mid_vld,
  output logic out_vld,
  output q2e_mat_t out_mat
);
  logic [1:0] vld;
  logic signed [31:0] xx, yy, zz, yz, wx, xz, wy, xy, wz;
  q2e_mat_t s2;
  q2e_mat_t mat_next;
  logic signed [MW-1:0] vc;

  assign mid_vld = vld;

  always_comb begin
    vc = -s2.v;
    if (vc > ONE_Q28) vc = ONE_Q28;
    if (vc < -ONE_Q28) vc = -ONE_Q28;
    mat_next = s2;
    mat_next.v = vc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld <= {vld[0], in_vld};
      out_vld <= vld[1];
    end
    if (adv) begin
      xx <= quat_x * quat_x; yy <= quat_y * quat_y; zz <= quat_z * quat_z;
      yz <= quat_y * quat_z; wx <= quat_w * quat_x; xz <= quat_x * quat_z;
      wy <= quat_w * quat_y; xy <= quat_x * quat_y; wz <= quat_w * quat_z;
      s2.m32 <= 34'(2 * (34'(yz) - 34'(wx)));
      s2.m33 <= ONE_Q28 - 34'(2 * (34'(xx) + 34'(yy)));
      s2.v <= 34'(2 * (34'(xz) + 34'(wy)));
      s2.m21 <= 34'(2 * (34'(xy) - 34'(wz)));
      s2.m11 <= ONE_Q28 - 34'(2 * (34'(yy) + 34'(zz)));
      out_mat <= mat_next;
    end
  end
endmodule
`default_nettype wire

@@ hdl/q2e_atan.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler CORDIC
// Pipelined vectoring CORDIC atan2, one iteration per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_atan
  import q2e_pkg::*;
#(
  parameter int STEPS = 14,
  parameter int FRAC = 13
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic signed [MW+1:0] yi,
  input  wire logic signed [MW+1:0] xi,
  output logic signed [ZW-1:0] ang
);
  localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
  localparam int SH = 30 - FRAC;
  logic signed [MW+3:0] xs [0:N];
  logic signed [MW+3:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic zero [0:N];

  always_ff @(posedge clk) begin
    if (adv) begin
      zero[0] <= (xi == 0) && (yi == 0);
      if (xi < 0) begin
        zs[0] <= (yi >= 0) ? PI_Q30 : -PI_Q30;
        xs[0] <= -(MW+4)'(xi);
        ys[0] <= -(MW+4)'(yi);
      end else begin
        zs[0] <= '0;
        xs[0] <= (MW+4)'(xi);
        ys[0] <= (MW+4)'(yi);
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (adv) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) ang <= zero[N] ? '0 : ((zs[N] + (ZW'(1) <<< (SH - 1))) >>> SH);
  end
endmodule
`default_nettype wire

@@ hdl/q2e_sqrt.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler square root
// Pipelined restoring square root of 1-v^2, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_sqrt
  import q2e_pkg::*;
(
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic signed [MW-1:0] v,
  output logic signed [MW-1:0] v_out,
  output logic [29:0] root
);
  localparam int NB = 29;
  logic [57:0] rem [0:NB];
  logic [29:0] res [0:NB];
  logic signed [MW-1:0] vp [0:NB];
  logic signed [29:0] vs;
  logic [57:0] vv;

  assign vs = v[29:0];

  always_comb vv = 58'h0100000000000000 - 58'(vs) * 58'(vs);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= vv;
      res[0] <= '0;
      vp[0] <= v;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_bit
    localparam int B = 2 * (NB - 1 - i);
    logic [59:0] tr;
    assign tr = 60'({res[i], 2'b01}) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        vp[i+1] <= vp[i];
        if (60'(rem[i]) >= tr) begin
          rem[i+1] <= 58'(60'(rem[i]) - tr);
          res[i+1] <= {res[i][28:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i];
          res[i+1] <= {res[i][28:0], 1'b0};
        end
      end
    end
  end

  assign root = res[NB];
  assign v_out = vp[NB];
endmodule
`default_nettype wire

@@ hdl/quaternion_to_euler.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler converter
// Matrix front end, square root, three pipelined CORDIC atan2 units, then a queue.
// ----------------------------------------------------------------------------
// An accepted word passes the front end, the square root and the CORDIC units,
// then the output queue and register; CORDIC_STEPS is capped at 24.
// Throughput: one word per cycle; the pipe never stops, and the input stalls
// only when the words in flight and in the queue fill its 64 entries.
// Reset: synchronous rst clears all valid bits and queue pointers; payload is not reset.
`default_nettype none
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = 14,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [QW-1:0] quat_x,
  input  wire logic signed [QW-1:0] quat_y,
  input  wire logic signed [QW-1:0] quat_z,
  input  wire logic signed [QW-1:0] quat_w,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] pitch_angle,
  output logic signed [14:0] yaw_angle,
  output logic signed [15:0] roll_angle
);
  localparam int NS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int LAT = 30 + NS + 2;
  localparam int QD = 64;
  localparam int CW = $clog2(QD + 1);

  logic adv, f_vld;
  logic [1:0] f_mid;
  q2e_mat_t f_mat;
  logic [LAT-1:0] vpipe;
  logic signed [MW-1:0] m32d [0:29];
  logic signed [MW-1:0] m33d [0:29];
  logic signed [MW-1:0] m21d [0:29];
  logic signed [MW-1:0] m11d [0:29];
  logic signed [MW-1:0] vq;
  logic [29:0] root;
  logic signed [ZW-1:0] ap, ay, ar;
  logic [CW-1:0] cnt;
  logic [15:0] qp [0:QD-1];
  logic [14:0] qy [0:QD-1];
  logic [15:0] qr [0:QD-1];
  logic [$clog2(QD)-1:0] wp, rp;
  logic push, pop, load, acc_in;
  logic [CW-1:0] inflight;

  assign pop = out_valid && !out_stall;
  assign push = vpipe[LAT-1];
  assign load = (cnt != '0) && (!out_valid || pop);
  assign inflight = CW'(cnt + CW'(out_valid) + CW'($countones({vpipe, f_vld, f_mid})));
  assign adv = 1'b1;
  assign in_stall = inflight >= CW'(QD);
  assign acc_in = in_valid && !in_stall;

  q2e_front u_front (
    .clk, .rst, .adv, .in_vld(acc_in), .quat_x, .quat_y, .quat_z, .quat_w,
    .mid_vld(f_mid), .out_vld(f_vld), .out_mat(f_mat)
  );

  q2e_sqrt u_sqrt (.clk, .adv, .v(f_mat.v), .v_out(vq), .root);

  always_ff @(posedge clk) begin
    m32d[0] <= f_mat.m32; m33d[0] <= f_mat.m33;
    m21d[0] <= f_mat.m21; m11d[0] <= f_mat.m11;
    for (int k = 1; k < 30; k++) begin
      m32d[k] <= m32d[k-1]; m33d[k] <= m33d[k-1];
      m21d[k] <= m21d[k-1]; m11d[k] <= m11d[k-1];
    end
  end

  q2e_atan #(.STEPS(NS), .FRAC(ANGLE_FRAC_BITS)) u_pitch (
    .clk, .adv, .yi((MW+2)'(m32d[29])), .xi((MW+2)'(m33d[29])), .ang(ap));
  q2e_atan #(.STEPS(NS), .FRAC(ANGLE_FRAC_BITS)) u_yaw (
    .clk, .adv, .yi((MW+2)'(vq)), .xi((MW+2)'({4'b0, root})), .ang(ay));
  q2e_atan #(.STEPS(NS), .FRAC(ANGLE_FRAC_BITS)) u_roll (
    .clk, .adv, .yi((MW+2)'(m21d[29])), .xi((MW+2)'(m11d[29])), .ang(ar));

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      cnt <= '0;
      wp <= '0;
      rp <= '0;
      out_valid <= 1'b0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], f_vld};
      if (push) wp <= wp + 1'b1;
      if (load) rp <= rp + 1'b1;
      cnt <= CW'(cnt + CW'(push) - CW'(load));
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qp[wp] <= ap[15:0];
      qy[wp] <= ay[14:0];
      qr[wp] <= ar[15:0];
    end
    if (load) begin
      pitch_angle <= qp[rp];
      yaw_angle <= qy[rp];
      roll_angle <= qr[rp];
    end
  end

  `include "quaternion_to_euler_assert.svh"
  `Q2E_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CW'(QD))
  `Q2E_ASSERT_IMP(a_credit_bound, 1'b1, inflight <= CW'(QD))
  `Q2E_ASSERT_IMP(a_no_load_empty, load, cnt != '0)
  `Q2E_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(pitch_angle))
endmodule
`default_nettype wire

@@ tb/quaternion_to_euler_tb.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler testbench
// Drives quaternion words through the converter with random idling on both
// sides, predicts pitch, yaw and roll with a behavioral CORDIC, and compares
// every output word in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;
  import q2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 14;
  localparam int FRAC = 13;
  localparam int N_RANDOM = 1880;
  localparam int TAIL = 3 + 30 + STEPS + 2 + 20;
  localparam longint LIMIT = 400000;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct {
    logic signed [15:0] x, y, z, w;
    bit known;
    angles_t ang;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pitch_angle;
  logic signed [14:0] yaw_angle;
  logic signed [15:0] roll_angle;

  angles_t expected_angles[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  longint cycles = 0;
  bit hold_rx = 0;
  bit calm = 0;

  quaternion_to_euler dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vec_angle(longint yv, longint xv);
    longint zacc = 0;
    longint dx, dy;
    longint tbl[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    longint pi30 = 64'd3373259426;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zacc = (yv >= 0) ? pi30 : -pi30;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = shr(yv, i);
      dy = shr(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; zacc += tbl[i];
      end else begin
        xv -= dx; yv += dy; zacc -= tbl[i];
      end
    end
    return shr(zacc + (longint'(1) << (29 - FRAC)), 30 - FRAC);
  endfunction

  function automatic longint root_floor(longint n);
    longint r = 0;
    longint b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qx, qy, qz, qw);
    longint x = qx, y = qy, z = qz, w = qw;
    longint one = longint'(1) << 28;
    longint m32, m33, m31, m21, m11, v, c, p, yw, r;
    angles_t a;
    m32 = 2 * (y * z - w * x);
    m33 = one - 2 * (x * x + y * y);
    m31 = 2 * (x * z + w * y);
    m21 = 2 * (x * y - w * z);
    m11 = one - 2 * (y * y + z * z);
    v = -m31;
    if (v > one) v = one;
    if (v < -one) v = -one;
    c = root_floor(one * one - v * v);
    p = vec_angle(m32, m33);
    yw = vec_angle(v, c);
    r = vec_angle(m21, m11);
    a.pitch = p[15:0];
    a.yaw = yw[14:0];
    a.roll = r[15:0];
    return a;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    int k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic row_t unit_quat();
    row_t q;
    real a, b, c, d, n;
    a = $urandom_range(0, 20000) - 10000.0;
    b = $urandom_range(0, 20000) - 10000.0;
    c = $urandom_range(0, 20000) - 10000.0;
    d = $urandom_range(0, 20000) - 10000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0; n = 1.0;
    end
    q.x = 16'($rtoi(16384.0 * a / n));
    q.y = 16'($rtoi(16384.0 * b / n));
    q.z = 16'($rtoi(16384.0 * c / n));
    q.w = 16'($rtoi(16384.0 * d / n));
    q.known = 0;
    return q;
  endfunction

  task automatic send_word(row_t q);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_x <= q.x;
    quat_y <= q.y;
    quat_z <= q.z;
    quat_w <= q.w;
    expected_angles.push_back(q.known ? q.ang : euler_of(q.x, q.y, q.z, q.w));
    words_in++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      angles_t e;
      if (expected_angles.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (pitch_angle !== e.pitch) begin
          $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
          errors++;
        end
        if (yaw_angle !== e.yaw) begin
          $error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
          errors++;
        end
        if (roll_angle !== e.roll) begin
          $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
          errors++;
        end
      end
      words_out++;
    end
    out_stall <= hold_rx || (!calm && $urandom_range(0, 99) < 9);
  end

  row_t stim[$];

  function automatic row_t mk(int x, int y, int z, int w, bit k = 0,
                              int p = 0, int yw = 0, int r = 0);
    row_t q;
    q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
    q.known = k;
    q.ang.pitch = 16'(p); q.ang.yaw = 15'(yw); q.ang.roll = 16'(r);
    return q;
  endfunction

  initial begin
    row_t q;
    // identity, all-zero and the half-plane flips
    stim.push_back(mk(0, 0, 0, 16384, 1, -1, -1, -1));
    stim.push_back(mk(0, 0, 0, -16384, 1, -1, -1, -1));
    stim.push_back(mk(0, 0, 0, 0, 1, -1, -1, -1));
    stim.push_back(mk(16384, 0, 0, 0));
    stim.push_back(mk(0, 16384, 0, 0));
    stim.push_back(mk(0, 0, 16384, 0));
    stim.push_back(mk(-16384, 0, 0, 0));
    stim.push_back(mk(0, -16384, 0, 0));
    stim.push_back(mk(0, 0, -16384, 0));
    stim.push_back(mk(11585, 11585, 0, 0));
    stim.push_back(mk(0, 11585, 0, 11585));
    stim.push_back(mk(0, -11585, 0, 11585));
    stim.push_back(mk(11585, 0, 11585, 0));
    stim.push_back(mk(16384, 16384, 16384, 16384));
    stim.push_back(mk(-16384, -16384, -16384, -16384));
    stim.push_back(mk(-32768, -32768, -32768, -32768));
    stim.push_back(mk(32767, 32767, 32767, 32767));
    stim.push_back(mk(32767, -32768, 32767, -32768));
    stim.push_back(mk(-1, -1, -1, -1));
    stim.push_back(mk(8192, 8192, 8192, 8192));
    stim.push_back(mk(-8192, 8192, -8192, 8192));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim[i]) send_word(stim[i]);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 1000) fork
        begin
          hold_rx = 1;
          repeat (200) @(posedge clk);
          hold_rx = 0;
        end
      join_none
      if (n == 1400) drain();
      if ($urandom_range(0, 4) == 0) begin
        q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
        q.known = 0;
      end else begin
        q = unit_quat();
      end
      send_word(q);
    end
    calm = 0;
    drain();
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d quaternion words, checked %0d angle words", words_in, words_out);
    $display("Covered axis extremes, out-of-range inputs, stalls and backpressure");
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ quaternion_to_euler.f @@
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_atan.sv
hdl/q2e_sqrt.sv
hdl/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
